// ----- hw/rtl/fpm_pkg.sv -----
// fpm_pkg: shared constants, command struct and twiddle rom for the fft polynomial multiplier
// used by fpm_ctrl, fpm_dp and the top level; depends on nothing
package fpm_pkg;

	localparam int MAX_LOG2 = 10;
	localparam int DEPTH    = 1 << MAX_LOG2;
	localparam int ADDR_W   = MAX_LOG2;
	localparam int TW_DEPTH = DEPTH / 2;
	localparam int TW_AW    = MAX_LOG2 - 1;
	localparam int TW_BITS  = 16;
	localparam int TW_SHIFT = TW_BITS - 1;
	localparam int TW_W     = TW_BITS + 1;
	localparam int DATA_W   = 48;
	localparam int WORD_W   = 2 * DATA_W;
	localparam int ACC_W    = 98;
	localparam int OUT_W    = 42;
	localparam int COEF_W   = 16;
	localparam int LG_W     = 4;
	localparam int OP_W     = 3;

	localparam longint unsigned PI_Q30 = 64'd3373259426;

	localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD1 = 3'd1;
	localparam logic [OP_W-1:0] OP_LOAD2 = 3'd2;
	localparam logic [OP_W-1:0] OP_RUN   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ  = 3'd4;

	// write data sources
	localparam logic [2:0] W_ZERO  = 3'd0;
	localparam logic [2:0] W_LOAD  = 3'd1;
	localparam logic [2:0] W_RDA   = 3'd2;
	localparam logic [2:0] W_RDB   = 3'd3;
	localparam logic [2:0] W_SUM   = 3'd4;
	localparam logic [2:0] W_DIFF  = 3'd5;
	localparam logic [2:0] W_PROD  = 3'd6;
	localparam logic [2:0] W_SCALE = 3'd7;

	// multiplier operand selects
	localparam logic [1:0] A_ORE = 2'd0;
	localparam logic [1:0] A_OIM = 2'd1;
	localparam logic [1:0] A_AR  = 2'd2;
	localparam logic [1:0] A_AI  = 2'd3;

	localparam logic [2:0] B_COS  = 3'd0;
	localparam logic [2:0] B_SIN  = 3'd1;
	localparam logic [2:0] B_BRLO = 3'd2;
	localparam logic [2:0] B_BRHI = 3'd3;
	localparam logic [2:0] B_BILO = 3'd4;
	localparam logic [2:0] B_BIHI = 3'd5;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr_a;
		logic [ADDR_W-1:0] rd_addr_b;
		logic              we_first;
		logic              we_second;
		logic [ADDR_W-1:0] waddr;
		logic [2:0]        wsrc;
		logic              sel;
		logic [TW_AW-1:0]  tw_idx;
		logic              mac_en;
		logic              mac_clr;
		logic              mac_neg;
		logic [1:0]        a_sel;
		logic [2:0]        b_sel;
		logic              rnd_re;
		logic              rnd_im;
		logic              rnd_sh;
		logic [LG_W-1:0]   lg;
		logic              out_ld;
		logic              out_rd;
		logic              out_done;
	} fpm_cmd_t;

	typedef logic signed [TW_W-1:0] tw_rom_t [TW_DEPTH];

	function automatic tw_rom_t tw_build(input logic want_sin);
		tw_rom_t rom;
		longint unsigned x;
		longint unsigned term;
		longint cs;
		longint sn;
		longint t;
		int kk;
		int n;
		int k;
		logic flip;
		for (k = 0; k < TW_DEPTH; k++) begin
			kk = k;
			flip = 1'b0;
			if (k > TW_DEPTH / 2) begin
				kk = TW_DEPTH - k;
				flip = 1'b1;
			end
			term = 64'd1 << 30;
			cs = 64'sd1 << 30;
			sn = 0;
			x = 64'(kk) * PI_Q30;
			if (MAX_LOG2 > 1)
				x = (x + (64'd1 << (MAX_LOG2 - 2))) >> (MAX_LOG2 - 1);
			for (n = 1; n < 28; n++) begin
				term = ((term * x) >> 30) / 64'(n);
				t = n[1] ? -longint'(term) : longint'(term);
				if (n[0])
					sn = sn + t;
				else
					cs = cs + t;
			end
			if (cs < 0) cs = 0;
			if (cs > (64'sd1 << 30)) cs = 64'sd1 << 30;
			if (sn < 0) sn = 0;
			if (sn > (64'sd1 << 30)) sn = 64'sd1 << 30;
			cs = (cs + (64'sd1 << (30 - TW_SHIFT - 1))) >>> (30 - TW_SHIFT);
			sn = (sn + (64'sd1 << (30 - TW_SHIFT - 1))) >>> (30 - TW_SHIFT);
			rom[k] = want_sin ? TW_W'(sn) : TW_W'(flip ? -cs : cs);
		end
		return rom;
	endfunction

	localparam tw_rom_t TW_COS = tw_build(1'b0);
	localparam tw_rom_t TW_SIN = tw_build(1'b1);

endpackage

// ----- hw/rtl/fpm_ctrl.sv -----
// fpm_ctrl: sequencer for clear, load, read and the fft convolution run
// depends on fpm_pkg; drives fpm_dp through fpm_pkg::fpm_cmd_t
module fpm_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fpm_pkg::OP_W-1:0]    op,
	input  logic [fpm_pkg::ADDR_W-1:0]  index,
	input  logic                        cfg_wen,
	input  logic [fpm_pkg::LG_W-1:0]    cfg_wdata,
	output logic                        out_valid,
	input  logic                        out_stall,
	output fpm_pkg::fpm_cmd_t           cmd
);

	localparam int AW = fpm_pkg::ADDR_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_RDOUT = 4'd2;
	localparam logic [3:0] S_RV    = 4'd3;
	localparam logic [3:0] S_RV_W1 = 4'd4;
	localparam logic [3:0] S_RV_W2 = 4'd5;
	localparam logic [3:0] S_BF_RD = 4'd6;
	localparam logic [3:0] S_BF_M  = 4'd7;
	localparam logic [3:0] S_PW_RD = 4'd8;
	localparam logic [3:0] S_PW_M  = 4'd9;
	localparam logic [3:0] S_SC_RD = 4'd10;
	localparam logic [3:0] S_SC_W  = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;

	localparam logic [1:0] PASS_FWD1 = 2'd0;
	localparam logic [1:0] PASS_FWD2 = 2'd1;
	localparam logic [1:0] PASS_INV  = 2'd2;

	localparam logic [AW:0]   ONE_N = (AW + 1)'(1);
	localparam logic [AW-1:0] ONE_A = AW'(1);

	logic [3:0]        state_q, state_d;
	logic [3:0]        ph_q, ph_d;
	logic [AW-1:0]     i_q, i_d;
	logic [3:0]        st_q, st_d;
	logic [1:0]        pass_q, pass_d;
	logic              init_q, init_d;
	logic [3:0]        size_q;
	logic              out_valid_q;
	logic              set_out;
	logic              accept;
	logic [3:0]        lg;
	logic [AW:0]       n_full;
	logic [AW:0]       n_m1;
	logic [AW-1:0]     n_last;
	logic [AW-1:0]     b_last;
	logic [AW-1:0]     rev_full;
	logic [AW-1:0]     rev_j;
	logic [AW-1:0]     hbit;
	logic [AW-1:0]     hmask;
	logic [AW-1:0]     k_idx;
	logic [AW-1:0]     e_addr;
	logic [AW-1:0]     o_addr;
	logic [AW-1:0]     tw_full;
	logic              inv;

	always_comb begin
		if (size_q == 4'd0)
			lg = 4'd1;
		else if (size_q > 4'(fpm_pkg::MAX_LOG2))
			lg = 4'(fpm_pkg::MAX_LOG2);
		else
			lg = size_q;
	end

	assign n_full = ONE_N << lg;
	assign n_m1   = n_full - ONE_N;
	assign n_last = n_m1[AW-1:0];
	assign b_last = n_last >> 1;

	always_comb begin
		for (int b = 0; b < AW; b++)
			rev_full[b] = i_q[AW-1-b];
	end
	assign rev_j = rev_full >> (4'(AW) - lg);

	assign hbit    = ONE_A << st_q;
	assign hmask   = hbit - ONE_A;
	assign k_idx   = i_q & hmask;
	assign e_addr  = ((i_q >> st_q) << (st_q + 4'd1)) | k_idx;
	assign o_addr  = e_addr | hbit;
	assign tw_full = k_idx << (4'(fpm_pkg::TW_AW) - st_q);
	assign inv     = (pass_q == PASS_INV);

	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.lg     = lg;
		cmd.sel    = (pass_q == PASS_FWD2);
		cmd.tw_idx = tw_full[fpm_pkg::TW_AW-1:0];
		state_d    = state_q;
		ph_d       = ph_q;
		i_d        = i_q;
		st_d       = st_q;
		pass_d     = pass_q;
		init_d     = init_q;
		set_out    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						fpm_pkg::OP_CLEAR: begin
							state_d = S_CLEAR;
							i_d     = '0;
						end
						fpm_pkg::OP_LOAD1: begin
							cmd.we_first = 1'b1;
							cmd.waddr    = index;
							cmd.wsrc     = fpm_pkg::W_LOAD;
							cmd.out_ld   = 1'b1;
							cmd.out_done = 1'b1;
							set_out      = 1'b1;
						end
						fpm_pkg::OP_LOAD2: begin
							cmd.we_second = 1'b1;
							cmd.waddr     = index;
							cmd.wsrc      = fpm_pkg::W_LOAD;
							cmd.out_ld    = 1'b1;
							cmd.out_done  = 1'b1;
							set_out       = 1'b1;
						end
						fpm_pkg::OP_RUN: begin
							state_d = S_RV;
							pass_d  = PASS_FWD1;
							i_d     = '0;
						end
						fpm_pkg::OP_READ: begin
							cmd.rd_en     = 1'b1;
							cmd.rd_addr_a = index;
							cmd.rd_addr_b = index;
							state_d       = S_RDOUT;
						end
						default: begin
							cmd.out_ld = 1'b1;
							set_out    = 1'b1;
						end
					endcase
				end
			end
			S_CLEAR: begin
				cmd.we_first  = 1'b1;
				cmd.we_second = 1'b1;
				cmd.waddr     = i_q;
				cmd.wsrc      = fpm_pkg::W_ZERO;
				if (i_q == '1) begin
					state_d = init_q ? S_IDLE : S_DONE;
					init_d  = 1'b0;
				end else begin
					i_d = i_q + ONE_A;
				end
			end
			S_RDOUT: begin
				cmd.out_ld   = 1'b1;
				cmd.out_rd   = 1'b1;
				cmd.out_done = 1'b1;
				set_out      = 1'b1;
				state_d      = S_IDLE;
			end
			// bit-reversal permutation
			S_RV: begin
				if (rev_j > i_q) begin
					cmd.rd_en     = 1'b1;
					cmd.rd_addr_a = i_q;
					cmd.rd_addr_b = rev_j;
					state_d       = S_RV_W1;
				end else if (i_q == n_last) begin
					state_d = S_BF_RD;
					i_d     = '0;
					st_d    = '0;
				end else begin
					i_d = i_q + ONE_A;
				end
			end
			S_RV_W1: begin
				cmd.we_first  = !cmd.sel;
				cmd.we_second = cmd.sel;
				cmd.waddr     = i_q;
				cmd.wsrc      = fpm_pkg::W_RDB;
				state_d       = S_RV_W2;
			end
			S_RV_W2: begin
				cmd.we_first  = !cmd.sel;
				cmd.we_second = cmd.sel;
				cmd.waddr     = rev_j;
				cmd.wsrc      = fpm_pkg::W_RDA;
				i_d           = i_q + ONE_A;
				state_d       = S_RV;
			end
			// butterflies
			S_BF_RD: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_addr_a = e_addr;
				cmd.rd_addr_b = o_addr;
				ph_d          = '0;
				state_d       = S_BF_M;
			end
			S_BF_M: begin
				ph_d = ph_q + 4'd1;
				unique case (ph_q)
					4'd0: begin
						cmd.mac_en  = 1'b1;
						cmd.mac_clr = 1'b1;
						cmd.a_sel   = fpm_pkg::A_ORE;
						cmd.b_sel   = fpm_pkg::B_COS;
					end
					4'd1: begin
						cmd.mac_en  = 1'b1;
						cmd.mac_neg = !inv;
						cmd.a_sel   = fpm_pkg::A_OIM;
						cmd.b_sel   = fpm_pkg::B_SIN;
					end
					4'd2: begin
						cmd.mac_en  = 1'b1;
						cmd.mac_clr = 1'b1;
						cmd.mac_neg = inv;
						cmd.a_sel   = fpm_pkg::A_ORE;
						cmd.b_sel   = fpm_pkg::B_SIN;
						cmd.rnd_re  = 1'b1;
						cmd.rnd_sh  = 1'b1;
					end
					4'd3: begin
						cmd.mac_en = 1'b1;
						cmd.a_sel  = fpm_pkg::A_OIM;
						cmd.b_sel  = fpm_pkg::B_COS;
					end
					4'd4: begin
						cmd.rnd_im = 1'b1;
						cmd.rnd_sh = 1'b1;
					end
					4'd5: begin
						cmd.we_first  = !cmd.sel;
						cmd.we_second = cmd.sel;
						cmd.waddr     = e_addr;
						cmd.wsrc      = fpm_pkg::W_SUM;
					end
					default: begin
						cmd.we_first  = !cmd.sel;
						cmd.we_second = cmd.sel;
						cmd.waddr     = o_addr;
						cmd.wsrc      = fpm_pkg::W_DIFF;
						state_d       = S_BF_RD;
						if (i_q == b_last) begin
							i_d = '0;
							if (st_q == lg - 4'd1) begin
								unique case (pass_q)
									PASS_FWD1: begin
										pass_d  = PASS_FWD2;
										state_d = S_RV;
									end
									PASS_FWD2: state_d = S_PW_RD;
									default:   state_d = S_SC_RD;
								endcase
							end else begin
								st_d = st_q + 4'd1;
							end
						end else begin
							i_d = i_q + ONE_A;
						end
					end
				endcase
			end
			// pointwise product
			S_PW_RD: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_addr_a = i_q;
				cmd.rd_addr_b = i_q;
				ph_d          = '0;
				state_d       = S_PW_M;
			end
			S_PW_M: begin
				ph_d = ph_q + 4'd1;
				unique case (ph_q)
					4'd0: begin
						cmd.mac_en  = 1'b1;
						cmd.mac_clr = 1'b1;
						cmd.a_sel   = fpm_pkg::A_AR;
						cmd.b_sel   = fpm_pkg::B_BRLO;
					end
					4'd1: begin
						cmd.mac_en = 1'b1;
						cmd.a_sel  = fpm_pkg::A_AR;
						cmd.b_sel  = fpm_pkg::B_BRHI;
					end
					4'd2: begin
						cmd.mac_en  = 1'b1;
						cmd.mac_neg = 1'b1;
						cmd.a_sel   = fpm_pkg::A_AI;
						cmd.b_sel   = fpm_pkg::B_BILO;
					end
					4'd3: begin
						cmd.mac_en  = 1'b1;
						cmd.mac_neg = 1'b1;
						cmd.a_sel   = fpm_pkg::A_AI;
						cmd.b_sel   = fpm_pkg::B_BIHI;
					end
					4'd4: begin
						cmd.mac_en  = 1'b1;
						cmd.mac_clr = 1'b1;
						cmd.a_sel   = fpm_pkg::A_AR;
						cmd.b_sel   = fpm_pkg::B_BILO;
						cmd.rnd_re  = 1'b1;
					end
					4'd5: begin
						cmd.mac_en = 1'b1;
						cmd.a_sel  = fpm_pkg::A_AR;
						cmd.b_sel  = fpm_pkg::B_BIHI;
					end
					4'd6: begin
						cmd.mac_en = 1'b1;
						cmd.a_sel  = fpm_pkg::A_AI;
						cmd.b_sel  = fpm_pkg::B_BRLO;
					end
					4'd7: begin
						cmd.mac_en = 1'b1;
						cmd.a_sel  = fpm_pkg::A_AI;
						cmd.b_sel  = fpm_pkg::B_BRHI;
					end
					4'd8: cmd.rnd_im = 1'b1;
					default: begin
						cmd.we_first = 1'b1;
						cmd.waddr    = i_q;
						cmd.wsrc     = fpm_pkg::W_PROD;
						if (i_q == n_last) begin
							i_d     = '0;
							pass_d  = PASS_INV;
							state_d = S_RV;
						end else begin
							i_d     = i_q + ONE_A;
							state_d = S_PW_RD;
						end
					end
				endcase
			end
			// divide by n
			S_SC_RD: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_addr_a = i_q;
				cmd.rd_addr_b = i_q;
				state_d       = S_SC_W;
			end
			S_SC_W: begin
				cmd.we_first = 1'b1;
				cmd.waddr    = i_q;
				cmd.wsrc     = fpm_pkg::W_SCALE;
				if (i_q == n_last) begin
					state_d = S_DONE;
				end else begin
					i_d     = i_q + ONE_A;
					state_d = S_SC_RD;
				end
			end
			S_DONE: begin
				cmd.out_ld   = 1'b1;
				cmd.out_done = 1'b1;
				set_out      = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ph_q        <= '0;
			i_q         <= '0;
			st_q        <= '0;
			pass_q      <= PASS_FWD1;
			init_q      <= 1'b1;
			size_q      <= 4'(fpm_pkg::MAX_LOG2);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			i_q     <= i_d;
			st_q    <= st_d;
			pass_q  <= pass_d;
			init_q  <= init_d;
			if (cfg_wen)
				size_q <= cfg_wdata;
			if (set_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/fpm_dp.sv -----
// fpm_dp: coefficient stores, twiddle rom, shared multiply-accumulate and write-back logic
// depends on fpm_pkg; controlled by fpm_ctrl
module fpm_dp (
	input  logic                                clk,
	input  fpm_pkg::fpm_cmd_t                   cmd,
	input  logic signed [fpm_pkg::COEF_W-1:0]   coef_re,
	input  logic signed [fpm_pkg::COEF_W-1:0]   coef_im,
	output logic signed [fpm_pkg::OUT_W-1:0]    prod_re,
	output logic signed [fpm_pkg::OUT_W-1:0]    prod_im,
	output logic                                done_res
);

	localparam int DW = fpm_pkg::DATA_W;
	localparam int WW = fpm_pkg::WORD_W;
	localparam int AC = fpm_pkg::ACC_W;
	localparam int OW = fpm_pkg::OUT_W;
	localparam int HB = DW / 2;
	localparam int BW = HB + 1;
	localparam int PW = DW + BW;

	function automatic logic signed [DW-1:0] sat48_acc(input logic signed [AC-1:0] v);
		if (v[AC-1:DW-1] == {(AC - DW + 1){v[AC-1]}})
			return v[DW-1:0];
		return v[AC-1] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
	endfunction

	function automatic logic signed [DW-1:0] sat48_sum(input logic signed [DW:0] v);
		if (v[DW] == v[DW-1])
			return v[DW-1:0];
		return v[DW] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
	endfunction

	function automatic logic signed [OW-1:0] sat42(input logic signed [DW:0] v);
		if (v[DW:OW-1] == {(DW - OW + 2){v[DW]}})
			return v[OW-1:0];
		return v[DW] ? {1'b1, {(OW - 1){1'b0}}} : {1'b0, {(OW - 1){1'b1}}};
	endfunction

	function automatic logic signed [DW-1:0] scale(input logic signed [DW-1:0] v,
		input logic [fpm_pkg::LG_W-1:0] lg);
		logic signed [DW:0] t;
		logic signed [DW:0] q;
		t = {v[DW-1], v} + ((DW + 1)'(1) << (lg - 4'd1));
		q = t >>> lg;
		return DW'(sat42(q));
	endfunction

	logic [WW-1:0] mem_f [fpm_pkg::DEPTH];
	logic [WW-1:0] mem_s [fpm_pkg::DEPTH];
	logic [WW-1:0] fa_q, fb_q, sa_q, sb_q;
	logic [WW-1:0] wdata;
	logic [WW-1:0] ua, ub;
	logic signed [fpm_pkg::TW_W-1:0] tw_cos_q, tw_sin_q;
	logic signed [DW-1:0] e_re, e_im, o_re, o_im, ar, ai, br, bi;
	logic signed [DW-1:0] t_re_q, t_im_q;
	logic signed [DW-1:0] mac_a;
	logic signed [BW-1:0] mac_b;
	logic                 mac_hi;
	logic signed [PW-1:0] prod;
	logic signed [AC-1:0] term;
	logic signed [AC-1:0] acc_q;
	logic signed [AC-1:0] rnd_v;
	logic signed [AC-1:0] rnd_r;
	logic signed [DW-1:0] rnd_sat;
	logic signed [OW-1:0] prod_re_q, prod_im_q;
	logic                 done_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			fa_q <= mem_f[cmd.rd_addr_a];
			fb_q <= mem_f[cmd.rd_addr_b];
		end
		if (cmd.we_first)
			mem_f[cmd.waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			sa_q <= mem_s[cmd.rd_addr_a];
			sb_q <= mem_s[cmd.rd_addr_b];
		end
		if (cmd.we_second)
			mem_s[cmd.waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		tw_cos_q <= fpm_pkg::TW_COS[cmd.tw_idx];
		tw_sin_q <= fpm_pkg::TW_SIN[cmd.tw_idx];
	end

	assign ua   = cmd.sel ? sa_q : fa_q;
	assign ub   = cmd.sel ? sb_q : fb_q;
	assign e_re = ua[WW-1:DW];
	assign e_im = ua[DW-1:0];
	assign o_re = ub[WW-1:DW];
	assign o_im = ub[DW-1:0];
	assign ar   = fa_q[WW-1:DW];
	assign ai   = fa_q[DW-1:0];
	assign br   = sa_q[WW-1:DW];
	assign bi   = sa_q[DW-1:0];

	always_comb begin
		unique case (cmd.a_sel)
			fpm_pkg::A_ORE: mac_a = o_re;
			fpm_pkg::A_OIM: mac_a = o_im;
			fpm_pkg::A_AR:  mac_a = ar;
			fpm_pkg::A_AI:  mac_a = ai;
		endcase
	end

	always_comb begin
		mac_hi = 1'b0;
		unique case (cmd.b_sel)
			fpm_pkg::B_COS:  mac_b = BW'(tw_cos_q);
			fpm_pkg::B_SIN:  mac_b = BW'(tw_sin_q);
			fpm_pkg::B_BRLO: mac_b = {1'b0, br[HB-1:0]};
			fpm_pkg::B_BRHI: begin
				mac_b  = {br[DW-1], br[DW-1:HB]};
				mac_hi = 1'b1;
			end
			fpm_pkg::B_BILO: mac_b = {1'b0, bi[HB-1:0]};
			fpm_pkg::B_BIHI: begin
				mac_b  = {bi[DW-1], bi[DW-1:HB]};
				mac_hi = 1'b1;
			end
			default: mac_b = '0;
		endcase
	end

	assign prod = mac_a * mac_b;
	assign term = mac_hi ? (AC'(prod) <<< HB) : AC'(prod);

	always_ff @(posedge clk) begin
		if (cmd.mac_en)
			acc_q <= (cmd.mac_clr ? '0 : acc_q) + (cmd.mac_neg ? -term : term);
	end

	// round half up and shift when rnd_sh is set, then saturate the accumulated sum
	assign rnd_v   = acc_q + (cmd.rnd_sh ? (AC'(1) <<< (fpm_pkg::TW_SHIFT - 1)) : '0);
	assign rnd_r   = cmd.rnd_sh ? (rnd_v >>> fpm_pkg::TW_SHIFT) : rnd_v;
	assign rnd_sat = sat48_acc(rnd_r);

	always_ff @(posedge clk) begin
		if (cmd.rnd_re)
			t_re_q <= rnd_sat;
		if (cmd.rnd_im)
			t_im_q <= rnd_sat;
	end

	always_comb begin
		unique case (cmd.wsrc)
			fpm_pkg::W_ZERO:  wdata = '0;
			fpm_pkg::W_LOAD:  wdata = {DW'(coef_re), DW'(coef_im)};
			fpm_pkg::W_RDA:   wdata = ua;
			fpm_pkg::W_RDB:   wdata = ub;
			fpm_pkg::W_SUM:   wdata = {sat48_sum({e_re[DW-1], e_re} + {t_re_q[DW-1], t_re_q}),
				sat48_sum({e_im[DW-1], e_im} + {t_im_q[DW-1], t_im_q})};
			fpm_pkg::W_DIFF:  wdata = {sat48_sum({e_re[DW-1], e_re} - {t_re_q[DW-1], t_re_q}),
				sat48_sum({e_im[DW-1], e_im} - {t_im_q[DW-1], t_im_q})};
			fpm_pkg::W_PROD:  wdata = {t_re_q, t_im_q};
			fpm_pkg::W_SCALE: wdata = {scale(ar, cmd.lg), scale(ai, cmd.lg)};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			prod_re_q <= cmd.out_rd ? sat42({ar[DW-1], ar}) : '0;
			prod_im_q <= cmd.out_rd ? sat42({ai[DW-1], ai}) : '0;
			done_q    <= cmd.out_done;
		end
	end

	assign prod_re  = prod_re_q;
	assign prod_im  = prod_im_q;
	assign done_res = done_q;

endmodule

// ----- hw/rtl/fft_polynomial_multiply_top.sv -----
// fft_polynomial_multiply_top: cyclic convolution of two complex polynomials by radix-2 fft
// depends on fpm_pkg, fpm_ctrl and fpm_dp
//
// Input channel (in_valid/in_stall) takes one op per transaction: clear both stores,
// load the first or second store at index, run the convolution, or read the first store.
// Output channel (out_valid/out_stall) returns exactly one transaction per op:
// prod_re/prod_im carry the saturated entry for a read and zero otherwise, done_res is 1
// for a known op. size_log2 (cfg_wen/cfg_wdata) sets N = 2^L, L clamped to 1..10.
// Run uses a single multiply-accumulate unit that works through each butterfly and
// each pointwise product one multiply at a time, and the store memories give one pair
// of reads or one write per cycle.
// One op is worked on at a time; a load may follow in the next cycle while the output
// register is free or being taken.
// After reset a clearing pass zeroes both stores with in_stall high; size_log2 resets to 10.
// While out_stall holds a result, in_stall stays high.
module fft_polynomial_multiply_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [fpm_pkg::OP_W-1:0]            op,
	input  logic [fpm_pkg::ADDR_W-1:0]          index,
	input  logic signed [fpm_pkg::COEF_W-1:0]   coef_re,
	input  logic signed [fpm_pkg::COEF_W-1:0]   coef_im,
	input  logic                                cfg_wen,
	input  logic [fpm_pkg::LG_W-1:0]            cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [fpm_pkg::OUT_W-1:0]    prod_re,
	output logic signed [fpm_pkg::OUT_W-1:0]    prod_im,
	output logic                                done_res
);

	fpm_pkg::fpm_cmd_t cmd;

	fpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.index     (index),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	fpm_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.coef_re  (coef_re),
		.coef_im  (coef_im),
		.prod_re  (prod_re),
		.prod_im  (prod_im),
		.done_res (done_res)
	);

endmodule
